@@ hw/rtl/kmdr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmdr_pkg
// Shared types and constants of the key matrix debounce and report unit.
// ----------------------------------------------------------------------------
package kmdr_pkg;

  localparam int unsigned CODE_W      = 8;
  localparam int unsigned SLOT_FIELDS = 6;
  localparam int unsigned USED_W      = 3;

  localparam logic [CODE_W-1:0] CNT_MAX          = 8'hFF;
  localparam logic [CODE_W-1:0] MOD_FIRST        = 8'hE0;
  localparam logic [CODE_W-1:0] MOD_LAST         = 8'hE7;
  localparam logic [CODE_W-1:0] THRESHOLD_RESET  = 8'd10;
  localparam logic [CODE_W-1:0] FN_KEYCODE_RESET = 8'hFF;

  // input commands
  localparam logic CMD_SCAN  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // configuration register indexes
  localparam logic REG_THRESHOLD  = 1'b0;
  localparam logic REG_FN_KEYCODE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } seq_state_t;

  // one key as read back from the key store
  typedef struct packed {
    logic [CODE_W-1:0] cnt;
    logic [CODE_W-1:0] code_n;
    logic [CODE_W-1:0] code_f;
  } key_rd_t;

  // sequencer to report builder
  typedef struct packed {
    logic clear;
    logic step;
    logic pressed;
  } rpt_ctl_t;

endpackage

@@ hw/rtl/kmdr_key_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmdr_key_store
// Press counter memory and two-layer keymap memory, one key per entry, with
// per-entry valid bits so that never-written entries read as zero.
// ----------------------------------------------------------------------------
module kmdr_key_store
  import kmdr_pkg::*;
#(
  parameter int unsigned KEYS   = 80,
  parameter int unsigned KEY_AW = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [KEY_AW-1:0] rd_addr,
  output key_rd_t           rd_data,
  input  logic              cnt_we,
  input  logic [KEY_AW-1:0] cnt_addr,
  input  logic [CODE_W-1:0] cnt_wdata,
  input  logic              map_we,
  input  logic              map_layer,
  input  logic [KEY_AW-1:0] map_addr,
  input  logic [CODE_W-1:0] map_wdata
);

  logic [CODE_W-1:0]   cnt_mem [KEYS];
  logic [2*CODE_W-1:0] map_mem [KEYS];   // fn layer in the upper byte

  logic [KEYS-1:0] cnt_vld_r;
  logic [KEYS-1:0] norm_vld_r;
  logic [KEYS-1:0] fn_vld_r;

  logic [CODE_W-1:0]   cnt_q_r;
  logic [2*CODE_W-1:0] map_q_r;
  logic                cnt_ok_r;
  logic                norm_ok_r;
  logic                fn_ok_r;

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_addr] <= cnt_wdata;
    end
    if (map_we && !map_layer) begin
      map_mem[map_addr][CODE_W-1:0] <= map_wdata;
    end
    if (map_we && map_layer) begin
      map_mem[map_addr][2*CODE_W-1:CODE_W] <= map_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cnt_q_r   <= cnt_mem[rd_addr];
      map_q_r   <= map_mem[rd_addr];
      cnt_ok_r  <= cnt_vld_r[rd_addr];
      norm_ok_r <= norm_vld_r[rd_addr];
      fn_ok_r   <= fn_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r  <= '0;
      norm_vld_r <= '0;
      fn_vld_r   <= '0;
    end else begin
      if (cnt_we) begin
        cnt_vld_r[cnt_addr] <= 1'b1;
      end
      if (map_we && !map_layer) begin
        norm_vld_r[map_addr] <= 1'b1;
      end
      if (map_we && map_layer) begin
        fn_vld_r[map_addr] <= 1'b1;
      end
    end
  end

  assign rd_data.cnt    = cnt_ok_r  ? cnt_q_r : '0;
  assign rd_data.code_n = norm_ok_r ? map_q_r[CODE_W-1:0] : '0;
  assign rd_data.code_f = fn_ok_r   ? map_q_r[2*CODE_W-1:CODE_W] : '0;

endmodule

@@ hw/rtl/kmdr_report.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmdr_report
// Debounce decision for one key per cycle and the boot report it builds:
// modifier byte, key slots, slot count and the Fn layer flag.
// ----------------------------------------------------------------------------
module kmdr_report
  import kmdr_pkg::*;
#(
  parameter int unsigned REPORT_KEYS = 6
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rpt_ctl_t                           ctl,
  input  key_rd_t                            rd,
  input  logic [CODE_W-1:0]                  thr,
  input  logic [CODE_W-1:0]                  fn_code,
  output logic                               cnt_we,
  output logic [CODE_W-1:0]                  cnt_wdata,
  output logic [CODE_W-1:0]                  modifier,
  output logic [REPORT_KEYS-1:0][CODE_W-1:0] slots
);

  localparam int unsigned SLOT_AW = (REPORT_KEYS > 1) ? $clog2(REPORT_KEYS) : 1;

  logic [USED_W-1:0]                  used_r,  used_nxt;
  logic [CODE_W-1:0]                  mod_r,   mod_nxt;
  logic [REPORT_KEYS-1:0][CODE_W-1:0] slot_r,  slot_nxt;
  logic                               fn_on_r, fn_on_nxt;

  logic              active;
  logic              fn_match;
  logic              layer_on;
  logic [CODE_W-1:0] cnt_now;
  logic [CODE_W-1:0] code;

  assign active   = used_r < USED_W'(REPORT_KEYS);
  assign fn_match = rd.code_n == fn_code;
  assign layer_on = fn_match || fn_on_r;
  assign code     = layer_on ? rd.code_f : rd.code_n;

  always_comb begin
    if (!ctl.pressed) begin
      cnt_now = '0;
    end else if (rd.cnt <= thr && rd.cnt != CNT_MAX) begin
      cnt_now = rd.cnt + CODE_W'(1);
    end else begin
      cnt_now = rd.cnt;
    end
  end

  // a full report freezes the rest of the scan, counters too
  assign cnt_we    = ctl.step && active;
  assign cnt_wdata = cnt_now;

  always_comb begin
    used_nxt  = used_r;
    mod_nxt   = mod_r;
    slot_nxt  = slot_r;
    fn_on_nxt = fn_on_r;
    if (ctl.clear) begin
      used_nxt = '0;
      mod_nxt  = '0;
      slot_nxt = '0;
    end else if (ctl.step && active) begin
      if (fn_match && rd.cnt != '0 && cnt_now == '0) begin
        fn_on_nxt = 1'b0;
      end else if (cnt_now > thr) begin
        fn_on_nxt = layer_on;
        if (code >= MOD_FIRST && code <= MOD_LAST) begin
          mod_nxt = mod_r | (CODE_W'(1) << code[2:0]);
        end else if (code != '0) begin
          slot_nxt[used_r[SLOT_AW-1:0]] = code;
          used_nxt = used_r + USED_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      mod_r   <= '0;
      slot_r  <= '0;
      fn_on_r <= 1'b0;
    end else begin
      used_r  <= used_nxt;
      mod_r   <= mod_nxt;
      slot_r  <= slot_nxt;
      fn_on_r <= fn_on_nxt;
    end
  end

  assign modifier = mod_r;
  assign slots    = slot_r;

  a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(REPORT_KEYS))
    else $error("report slot count beyond report size");

  a_full_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.step && !active) |=> (used_r == $past(used_r) && mod_r == $past(mod_r)))
    else $error("full report changed during scan");

endmodule

@@ hw/rtl/key_matrix_debounce_report_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_debounce_report_unit
// Debounced key matrix scanner that builds a keyboard boot report.
// ----------------------------------------------------------------------------
// Scan beats carry one sensed matrix row; row 0 opens a scan and clears the
// report, the last row sends the report (modifier byte and six key slots).
// Write beats load the normal or Fn keymap. A scan beat fetches the first
// key, then decides one key per cycle, set by the single read port of the
// counter and keymap memories, the next key being fetched while the current
// one is decided and written back. The last row then passes through the emit
// state to load the output register, and waits there while the previous
// report is still not taken. No input is taken while a scan is in flight.
// Counters and keymaps are zero after reset with no clearing pass, so the
// block is ready straight after reset.
// ----------------------------------------------------------------------------
module key_matrix_debounce_report_unit
  import kmdr_pkg::*;
#(
  parameter int unsigned ROWS        = 10,
  parameter int unsigned COLS        = 8,
  parameter int unsigned REPORT_KEYS = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [3:0]        in_row,
  input  logic [7:0]        in_sense,
  input  logic [2:0]        in_column,
  input  logic              in_layer,
  input  logic [7:0]        in_keycode,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_modifier,
  output logic [7:0]        out_key0,
  output logic [7:0]        out_key1,
  output logic [7:0]        out_key2,
  output logic [7:0]        out_key3,
  output logic [7:0]        out_key4,
  output logic [7:0]        out_key5,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data
);

  localparam int unsigned KEYS   = ROWS * COLS;
  localparam int unsigned KEY_AW = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int unsigned COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);

  seq_state_t state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [KEY_AW-1:0] base_r;
  logic [COLS-1:0]   sense_r;
  logic              last_row_r;

  logic [CODE_W-1:0] thr_r;
  logic [CODE_W-1:0] fn_code_r;

  logic                               out_valid_r;
  logic [CODE_W-1:0]                  out_mod_r;
  logic [SLOT_FIELDS-1:0][CODE_W-1:0] out_key_r;
  logic                               out_load;

  logic              in_fire;
  logic              row_ok;
  logic              col_ok;
  logic              scan_start;
  logic [7:0]        in_prod;
  logic [KEY_AW-1:0] in_base;

  logic              rd_en;
  logic [KEY_AW-1:0] rd_addr;
  key_rd_t           rd_data;
  rpt_ctl_t          ctl;
  logic              cnt_we;
  logic [CODE_W-1:0] cnt_wdata;
  logic              map_we;
  logic [KEY_AW-1:0] map_addr;

  logic [CODE_W-1:0]                  rpt_mod;
  logic [REPORT_KEYS-1:0][CODE_W-1:0] rpt_slots;
  logic [SLOT_FIELDS-1:0][CODE_W-1:0] rpt_pad;

  assign in_ready   = state_r == ST_IDLE;
  assign in_fire    = in_valid && in_ready;
  assign row_ok     = {1'b0, in_row} < 5'(ROWS);
  assign col_ok     = {1'b0, in_column} < 4'(COLS);
  assign in_prod    = {4'b0, in_row} * 8'(COLS);
  assign in_base    = in_prod[KEY_AW-1:0];
  assign scan_start = in_fire && row_ok && in_cmd == CMD_SCAN;

  assign map_we   = in_fire && row_ok && col_ok && in_cmd == CMD_WRITE;
  assign map_addr = in_base + KEY_AW'(in_column);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THRESHOLD_RESET;
      fn_code_r <= FN_KEYCODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD:  thr_r     <= cfg_data;
        REG_FN_KEYCODE: fn_code_r <= cfg_data;
        default:        thr_r     <= thr_r;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    rd_en     = 1'b0;
    rd_addr   = in_base;
    ctl       = '0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (scan_start) begin
          rd_en     = 1'b1;
          ctl.clear = in_row == '0;
          col_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctl.step    = 1'b1;
        ctl.pressed = sense_r[col_r];
        if (col_r != COL_LAST) begin
          // fetch the next key while this one is decided
          rd_en   = 1'b1;
          rd_addr = base_r + KEY_AW'(col_r) + KEY_AW'(1);
          col_nxt = col_r + COL_W'(1);
        end else begin
          state_nxt = last_row_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      base_r     <= in_base;
      sense_r    <= in_sense[COLS-1:0];
      last_row_r <= in_row == 4'(ROWS - 1);
    end
  end

  kmdr_key_store #(
    .KEYS   (KEYS),
    .KEY_AW (KEY_AW)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .cnt_we    (cnt_we),
    .cnt_addr  (base_r + KEY_AW'(col_r)),
    .cnt_wdata (cnt_wdata),
    .map_we    (map_we),
    .map_layer (in_layer),
    .map_addr  (map_addr),
    .map_wdata (in_keycode)
  );

  kmdr_report #(
    .REPORT_KEYS (REPORT_KEYS)
  ) u_report (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .rd        (rd_data),
    .thr       (thr_r),
    .fn_code   (fn_code_r),
    .cnt_we    (cnt_we),
    .cnt_wdata (cnt_wdata),
    .modifier  (rpt_mod),
    .slots     (rpt_slots)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // slot fields past the report size stay zero
  always_comb begin
    rpt_pad                  = '0;
    rpt_pad[REPORT_KEYS-1:0] = rpt_slots;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mod_r <= rpt_mod;
      out_key_r <= rpt_pad;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_modifier = out_mod_r;
  assign out_key0     = out_key_r[0];
  assign out_key1     = out_key_r[1];
  assign out_key2     = out_key_r[2];
  assign out_key3     = out_key_r[3];
  assign out_key4     = out_key_r[4];
  assign out_key5     = out_key_r[5];

  a_cnt_wr_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_we |-> state_r == ST_SCAN)
    else $error("counter written outside a scan");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && col_r == COL_LAST && !last_row_r) |=> state_r == ST_IDLE)
    else $error("scan of an inner row did not return to idle");

  a_report_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("report sent outside the last row");

endmodule

@@ bench/key_matrix_debounce_report_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_debounce_report_unit_tb
// Self-checking bench for the key matrix debounce and report unit.
// ----------------------------------------------------------------------------
// A short table of directed beats comes first: keymap loads, out-of-range
// rows, a full report, the Fn layer and rows out of order. Random scans
// follow, mostly ascending rows with held keys that bounce now and then,
// and some keymap writes and stray rows mixed in. Every accepted beat goes
// through a local model of the scanner, and each report that comes out is
// compared field by field with the oldest one still owed. The settings are
// changed between phases while the block is idle, and the phases cycle
// through four ways of idling the two channels.
// ----------------------------------------------------------------------------
module key_matrix_debounce_report_unit_tb;
  import kmdr_pkg::*;

  localparam int ROWS        = 10;
  localparam int COLS        = 8;
  localparam int REPORT_KEYS = 6;
  localparam int KEYS        = ROWS * COLS;

  localparam int PHASES        = 8;
  localparam int PHASE_BEATS   = 190;
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_CYCLES  = 50;
  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_AFTER    = 12;
  localparam int HOLD_CYCLES   = 400;

  typedef struct packed {
    logic       cmd;
    logic [3:0] row;
    logic [7:0] sense;
    logic [2:0] column;
    logic       layer;
    logic [7:0] keycode;
  } key_beat_t;

  typedef struct packed {
    logic [7:0] modifier;
    logic [7:0] key0;
    logic [7:0] key1;
    logic [7:0] key2;
    logic [7:0] key3;
    logic [7:0] key4;
    logic [7:0] key5;
  } boot_report_t;

  typedef struct packed {
    key_beat_t    beat;
    logic         typed;
    boot_report_t report;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic       in_cmd;
  logic [3:0] in_row;
  logic [7:0] in_sense;
  logic [2:0] in_column;
  logic       in_layer;
  logic [7:0] in_keycode;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_modifier;
  logic [7:0] out_key0;
  logic [7:0] out_key1;
  logic [7:0] out_key2;
  logic [7:0] out_key3;
  logic [7:0] out_key4;
  logic [7:0] out_key5;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;

  // scanner model
  logic [7:0] key_count [KEYS];
  logic [7:0] keymap [2*KEYS];
  logic [7:0] slot_codes [REPORT_KEYS];
  logic       fn_active;
  int         slot_fill;
  logic [7:0] mod_mask;
  logic [7:0] thr_reg;
  logic [7:0] fn_code_reg;

  stim_row_t    scan_table [$];
  boot_report_t pending_reports [$];

  int tx_idle_pct    = 0;
  int rx_stall_pct   = 0;
  int mismatch_count = 0;
  int reports_seen   = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;
  int quiet_cycles   = 0;

  logic [55:0] want_bits;
  logic [55:0] got_bits;
  string       field_name;
  int          f;

  key_matrix_debounce_report_unit #(
    .ROWS(ROWS),
    .COLS(COLS),
    .REPORT_KEYS(REPORT_KEYS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_row(in_row),
    .in_sense(in_sense),
    .in_column(in_column),
    .in_layer(in_layer),
    .in_keycode(in_keycode),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_modifier(out_modifier),
    .out_key0(out_key0),
    .out_key1(out_key1),
    .out_key2(out_key2),
    .out_key3(out_key3),
    .out_key4(out_key4),
    .out_key5(out_key5),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task add_row(input logic cmd, input logic [3:0] row, input logic [7:0] sense,
               input logic [2:0] column, input logic layer, input logic [7:0] keycode,
               input logic typed, input boot_report_t report);
    stim_row_t s;
    s.beat   = {cmd, row, sense, column, layer, keycode};
    s.typed  = typed;
    s.report = report;
    scan_table.push_back(s);
  endtask

  // work one accepted beat through the model; got is set when a report is due
  task build_boot_report(input key_beat_t b, output logic got, output boot_report_t rep);
    int         j;
    int         idx;
    logic [7:0] code;
    logic [7:0] prev;
    logic [7:0] nxt;
    got = 1'b0;
    rep = '0;
    if (b.row < ROWS) begin
      if (b.cmd == CMD_WRITE) begin
        keymap[b.layer * KEYS + b.row * COLS + b.column] = b.keycode;
      end else begin
        if (b.row == 0) begin
          for (j = 0; j < REPORT_KEYS; j++) slot_codes[j] = 8'h00;
          slot_fill = 0;
          mod_mask  = 8'h00;
        end
        for (j = 0; j < COLS; j++) begin
          // once the report is full the rest of the row is left alone
          if (slot_fill < REPORT_KEYS) begin
            idx  = b.row * COLS + j;
            code = keymap[idx];
            prev = key_count[idx];
            nxt  = prev;
            if (b.sense[j]) begin
              if (nxt <= thr_reg && nxt != 8'hFF) nxt = nxt + 8'd1;
            end else begin
              nxt = 8'h00;
            end
            key_count[idx] = nxt;
            if (code == fn_code_reg && prev != 8'h00 && nxt == 8'h00) begin
              fn_active = 1'b0;
            end else if (nxt > thr_reg) begin
              if (code == fn_code_reg) fn_active = 1'b1;
              if (fn_active) code = keymap[KEYS + idx];
              if (code >= MOD_FIRST && code <= MOD_LAST) begin
                mod_mask[code[2:0]] = 1'b1;
              end else if (code != 8'h00) begin
                slot_codes[slot_fill] = code;
                slot_fill++;
              end
            end
          end
        end
        if (b.row == ROWS - 1) begin
          got = 1'b1;
          rep = {mod_mask, slot_codes[0], slot_codes[1], slot_codes[2],
                 slot_codes[3], slot_codes[4], slot_codes[5]};
        end
      end
    end
  endtask

  task offer_beat(input key_beat_t b);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid   <= 1'b1;
    in_cmd     <= b.cmd;
    in_row     <= b.row;
    in_sense   <= b.sense;
    in_column  <= b.column;
    in_layer   <= b.layer;
    in_keycode <= b.keycode;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // only called with the input side parked
  task load_settings(input logic [7:0] thr, input logic [7:0] fn);
    while (pending_reports.size() != 0) @(posedge clk);
    // a row with no report may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    cfg_index <= REG_FN_KEYCODE;
    cfg_data  <= fn;
    @(posedge clk);
    cfg_we      <= 1'b0;
    thr_reg     = thr;
    fn_code_reg = fn;
  endtask

  // report checker and receiver pacing
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      reports_seen <= reports_seen + 1;
      got_bits = {out_modifier, out_key0, out_key1, out_key2, out_key3, out_key4, out_key5};
      if (pending_reports.size() == 0) begin
        $display("%0t: report with none expected: expected none, actual %h", $time, got_bits);
        mismatch_count++;
      end else begin
        want_bits = pending_reports.pop_front();
        for (f = 0; f < 7; f++) begin
          if (want_bits[55-8*f -: 8] != got_bits[55-8*f -: 8]) begin
            if (f == 0) field_name = "modifier";
            else field_name = $sformatf("key%0d", f - 1);
            $display("%0t: %s expected %02h, actual %02h", $time, field_name,
                     want_bits[55-8*f -: 8], got_bits[55-8*f -: 8]);
            mismatch_count++;
          end
        end
      end
    end
    // one long hold-off so the block backs up onto its input
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (reports_seen == HOLD_AFTER && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("key_matrix_debounce_report_unit test failed");
      $finish;
    end
  end

  initial begin
    key_beat_t    beat;
    boot_report_t rep;
    logic         got;
    logic [31:0]  rnd;
    logic [7:0]   thr;
    logic [7:0]   fn;
    logic [7:0]   held [ROWS];
    int           dice;
    int           pick;
    int           next_row;
    int           ph;
    int           n;
    int           r;

    in_valid   <= 1'b0;
    in_cmd     <= CMD_SCAN;
    in_row     <= 4'd0;
    in_sense   <= 8'h00;
    in_column  <= 3'd0;
    in_layer   <= 1'b0;
    in_keycode <= 8'h00;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_THRESHOLD;
    cfg_data   <= 8'h00;
    rst_n      <= 1'b0;

    for (r = 0; r < KEYS; r++) key_count[r] = 8'h00;
    for (r = 0; r < 2 * KEYS; r++) keymap[r] = 8'h00;
    for (r = 0; r < REPORT_KEYS; r++) slot_codes[r] = 8'h00;
    fn_active   = 1'b0;
    slot_fill   = 0;
    mod_mask    = 8'h00;
    thr_reg     = THRESHOLD_RESET;
    fn_code_reg = FN_KEYCODE_RESET;

    // last row straight after reset, empty keymaps
    add_row(CMD_SCAN,  4'd9,  8'h00, 3'd0, 1'b0, 8'h00, 1'b1, '0);
    // out-of-range row, write and scan both ignored
    add_row(CMD_WRITE, 4'd15, 8'h00, 3'd0, 1'b0, 8'hAA, 1'b0, '0);
    add_row(CMD_SCAN,  4'd15, 8'hFF, 3'd0, 1'b0, 8'h00, 1'b0, '0);
    add_row(CMD_WRITE, 4'd0,  8'h00, 3'd0, 1'b0, 8'hE0, 1'b0, '0);
    add_row(CMD_WRITE, 4'd0,  8'h00, 3'd7, 1'b0, 8'hFF, 1'b0, '0);
    add_row(CMD_WRITE, 4'd9,  8'h00, 3'd7, 1'b1, 8'hE7, 1'b0, '0);
    add_row(CMD_WRITE, 4'd9,  8'h00, 3'd0, 1'b0, 8'h00, 1'b0, '0);
    add_row(CMD_WRITE, 4'd3,  8'h00, 3'd0, 1'b0, 8'h01, 1'b0, '0);
    add_row(CMD_WRITE, 4'd3,  8'h00, 3'd1, 1'b0, 8'h02, 1'b0, '0);
    add_row(CMD_WRITE, 4'd3,  8'h00, 3'd2, 1'b0, 8'h03, 1'b0, '0);
    add_row(CMD_WRITE, 4'd3,  8'h00, 3'd3, 1'b0, 8'h04, 1'b0, '0);
    add_row(CMD_WRITE, 4'd3,  8'h00, 3'd4, 1'b0, 8'h05, 1'b0, '0);
    add_row(CMD_WRITE, 4'd3,  8'h00, 3'd5, 1'b0, 8'h06, 1'b0, '0);
    add_row(CMD_WRITE, 4'd3,  8'h00, 3'd6, 1'b0, 8'h07, 1'b0, '0);
    // left control, then a row that fills all six slots and skips the rest
    add_row(CMD_SCAN,  4'd0,  8'h01, 3'd0, 1'b0, 8'h00, 1'b0, '0);
    add_row(CMD_SCAN,  4'd3,  8'hFF, 3'd0, 1'b0, 8'h00, 1'b0, '0);
    add_row(CMD_SCAN,  4'd9,  8'h00, 3'd0, 1'b0, 8'h00, 1'b1,
            {8'h01, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06});
    // Fn held: last row takes its code from the Fn keymap
    add_row(CMD_SCAN,  4'd0,  8'h80, 3'd0, 1'b0, 8'h00, 1'b0, '0);
    add_row(CMD_SCAN,  4'd9,  8'h80, 3'd0, 1'b0, 8'h00, 1'b1, {8'h80, 48'h0});
    // Fn released drops the layer
    add_row(CMD_SCAN,  4'd0,  8'h00, 3'd0, 1'b0, 8'h00, 1'b0, '0);
    add_row(CMD_SCAN,  4'd9,  8'hFF, 3'd0, 1'b0, 8'h00, 1'b1, '0);
    add_row(CMD_SCAN,  4'd3,  8'h00, 3'd0, 1'b0, 8'h00, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    load_settings(8'd0, FN_KEYCODE_RESET);
    foreach (scan_table[i]) begin
      offer_beat(scan_table[i].beat);
      build_boot_report(scan_table[i].beat, got, rep);
      if (got) pending_reports.push_back(scan_table[i].typed ? scan_table[i].report : rep);
    end
    in_valid <= 1'b0;

    for (r = 0; r < ROWS; r++) held[r] = 8'($urandom);
    next_row = 0;

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin thr = 8'd0;             fn = FN_KEYCODE_RESET; end
        1: begin thr = 8'hFF;            fn = 8'h00;            end
        2: begin thr = 8'd1;             fn = 8'($urandom);     end
        3: begin thr = 8'd2;             fn = FN_KEYCODE_RESET; end
        4: begin thr = 8'd254;           fn = MOD_FIRST;        end
        5: begin thr = 8'($urandom_range(4)); fn = 8'($urandom); end
        6: begin thr = 8'd3;             fn = 8'h00;            end
        default: begin thr = THRESHOLD_RESET; fn = 8'($urandom); end
      endcase
      load_settings(thr, fn);
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 88; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 88; end
        default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
      endcase

      for (n = 0; n < PHASE_BEATS; n++) begin
        rnd  = $urandom;
        beat = rnd[24:0];
        dice = $urandom_range(99);
        if (dice < 12) begin
          beat.cmd = CMD_WRITE;
          if ($urandom_range(9) == 0) beat.row = 4'($urandom_range(15, 10));
          else beat.row = 4'($urandom_range(ROWS - 1));
          pick = $urandom_range(99);
          if (pick < 25) beat.keycode = 8'h00;
          else if (pick < 45) beat.keycode = MOD_FIRST | 8'($urandom_range(7));
          else if (pick < 55) beat.keycode = fn_code_reg;
          else if (pick < 60) beat.keycode = 8'hFF;
        end else if (dice < 16) begin
          // stray row with random sense
          beat.cmd = CMD_SCAN;
        end else begin
          beat.cmd = CMD_SCAN;
          beat.row = 4'(next_row);
          if (next_row == 0) begin
            if ($urandom_range(49) == 0) begin
              for (r = 0; r < ROWS; r++) held[r] = 8'h00;
            end
            for (r = 0; r < ROWS; r++) begin
              if ($urandom_range(99) < 15) begin
                pick = $urandom_range(COLS - 1);
                held[r][pick] = ~held[r][pick];
              end
            end
          end
          beat.sense = held[next_row];
          // contact bounce
          if ($urandom_range(9) == 0) begin
            pick = $urandom_range(COLS - 1);
            beat.sense[pick] = ~beat.sense[pick];
          end
          next_row++;
          if ($urandom_range(29) == 0) next_row++;
          if (next_row >= ROWS) next_row = 0;
        end
        offer_beat(beat);
        build_boot_report(beat, got, rep);
        if (got) pending_reports.push_back(rep);
      end
      in_valid <= 1'b0;
    end

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("key_matrix_debounce_report_unit test passed");
    else
      $display("key_matrix_debounce_report_unit test failed");
    $finish;
  end

endmodule
